FILE: sv/fspd_pkg.sv
// Package: shared constants, types and helpers for the palette dither core.
package fspd_pkg;

	localparam int MAX_PALETTE = 256;
	localparam int MAX_WIDTH = 4096;
	localparam int ERROR_BITS = 20;

	localparam int COMP_BITS = 16;
	localparam int ROW_WIDTH_BITS = 13;
	localparam int PALETTE_COUNT_BITS = 9;
	localparam int CFG_BITS = 13;
	localparam int ENTRY_INDEX_BITS = 8;
	localparam int PALETTE_INDEX_BITS = 8;

	localparam int IDX_BITS = $clog2(MAX_PALETTE);
	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int W_BITS = (COL_BITS + 1 > ROW_WIDTH_BITS) ? COL_BITS + 1 : ROW_WIDTH_BITS;
	localparam int N_BITS = (IDX_BITS + 1 > PALETTE_COUNT_BITS) ? IDX_BITS + 1 : PALETTE_COUNT_BITS;

	localparam int T_BITS = ERROR_BITS + 2;
	localparam int PROD_BITS = T_BITS + (T_BITS - 8);
	localparam int DIST_BITS = PROD_BITS + 2;
	localparam int WIDE_BITS = ERROR_BITS + 6;

	localparam int ENT_BITS = 3 * COMP_BITS;
	localparam int ERR_WORD_BITS = 3 * ERROR_BITS;

	localparam int ROW_WIDTH_RESET = 640;
	localparam int PALETTE_COUNT_RESET = 256;

	typedef enum logic [0:0] {
		REG_ROW_WIDTH     = 1'b0,
		REG_PALETTE_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_PIX,
		ST_VAL,
		ST_C0,
		ST_C1,
		ST_C2,
		ST_DIFF,
		ST_WR2,
		ST_DONE
	} state_t;

	typedef logic signed [ERROR_BITS-1:0] err_t;
	typedef logic signed [WIDE_BITS-1:0] wide_t;
	typedef logic signed [T_BITS-1:0] t_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [DIST_BITS-1:0] dist_t;

	localparam wide_t SAT_HI = wide_t'((64'sd1 <<< (ERROR_BITS - 1)) - 64'sd1);
	localparam wide_t SAT_LO = wide_t'(-(64'sd1 <<< (ERROR_BITS - 1)));

	function automatic err_t sat(input wide_t v);
		err_t r;
		if (v > SAT_HI) r = err_t'(SAT_HI);
		else if (v < SAT_LO) r = err_t'(SAT_LO);
		else r = err_t'(v);
		return r;
	endfunction

	// divide by 16, truncating toward zero
	function automatic wide_t div16(input wide_t v);
		wide_t r;
		if (v < 0) r = (v + wide_t'(15)) >>> 4;
		else r = v >>> 4;
		return r;
	endfunction

endpackage

FILE: sv/floyd_steinberg_palette_dither_core.sv
// Top level: Floyd-Steinberg palette dither with sequential nearest-entry search.
//
//  channel | signals                                              | dir
//  in      | in_valid in_ready mode entry_index red green blue    | in
//          | frame_start                                          |
//  out     | out_valid out_ready palette_index row_end            | out
//  cfg     | cfg_write cfg_index cfg_data                         | in
//
// A palette write goes straight into the palette RAM. A pixel's search is paced by
// the shared distance unit doing one component per cycle; a row end adds an error row write.
// Frame start adds a sweep clearing all MAX_WIDTH words of the error row RAM.
// After reset the same sweep runs before the first word is taken.
// The next input word is taken while a result word waits in the output register.
module floyd_steinberg_palette_dither_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    mode,
	input  logic [fspd_pkg::ENTRY_INDEX_BITS-1:0]   entry_index,
	input  logic [fspd_pkg::COMP_BITS-1:0]          red,
	input  logic [fspd_pkg::COMP_BITS-1:0]          green,
	input  logic [fspd_pkg::COMP_BITS-1:0]          blue,
	input  logic                                    frame_start,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [fspd_pkg::PALETTE_INDEX_BITS-1:0] palette_index,
	output logic                                    row_end,
	input  logic                                    cfg_write,
	input  fspd_pkg::reg_idx_t                      cfg_index,
	input  logic [fspd_pkg::CFG_BITS-1:0]           cfg_data
);

	fspd_pkg::state_t state_q, state_d;

	logic [fspd_pkg::ROW_WIDTH_BITS-1:0] row_width_q;
	logic [fspd_pkg::PALETTE_COUNT_BITS-1:0] palette_count_q;
	logic [fspd_pkg::W_BITS-1:0] w_eff;
	logic [fspd_pkg::N_BITS-1:0] n_eff;
	logic [fspd_pkg::IDX_BITS-1:0] n_last;

	logic [fspd_pkg::COMP_BITS-1:0] pix_q [3];
	fspd_pkg::err_t val_q [3];
	fspd_pkg::err_t rc_q [3];
	fspd_pkg::err_t bl_q [3];
	fspd_pkg::err_t bh_q [3];
	fspd_pkg::err_t ln_q [3];
	fspd_pkg::err_t val_d [3];
	fspd_pkg::err_t below [3];
	fspd_pkg::err_t bl_new [3];
	fspd_pkg::err_t ln_new [3];
	fspd_pkg::err_t rc_new [3];
	fspd_pkg::err_t bh_new [3];

	logic [fspd_pkg::COL_BITS-1:0] col_q, x_q, clr_q;
	logic pix_pend_q;
	logic last_q, last_d;
	logic [fspd_pkg::IDX_BITS-1:0] i_q, best_q;
	logic [fspd_pkg::ENT_BITS-1:0] best_ent_q;
	fspd_pkg::dist_t acc_q, best_dist_q, dist_sum;
	logic out_valid_q;
	logic [fspd_pkg::PALETTE_INDEX_BITS-1:0] palette_index_q;
	logic row_end_q;

	logic accept, load_out;

	logic pal_we;
	logic [fspd_pkg::IDX_BITS-1:0] pal_raddr;
	logic [fspd_pkg::ENT_BITS-1:0] pal_rdata;

	logic err_we;
	logic [fspd_pkg::COL_BITS-1:0] err_waddr, err_raddr, x_d;
	logic [fspd_pkg::ERR_WORD_BITS-1:0] err_wdata, err_rdata;

	logic [fspd_pkg::COMP_BITS-1:0] comp_sel;
	fspd_pkg::err_t val_sel;
	fspd_pkg::prod_t prod;

	// effective register values
	always_comb begin
		if (row_width_q == '0) w_eff = fspd_pkg::W_BITS'(1);
		else if (fspd_pkg::W_BITS'(row_width_q) > fspd_pkg::W_BITS'(fspd_pkg::MAX_WIDTH))
			w_eff = fspd_pkg::W_BITS'(fspd_pkg::MAX_WIDTH);
		else w_eff = fspd_pkg::W_BITS'(row_width_q);
		if (palette_count_q == '0) n_eff = fspd_pkg::N_BITS'(1);
		else if (fspd_pkg::N_BITS'(palette_count_q) > fspd_pkg::N_BITS'(fspd_pkg::MAX_PALETTE))
			n_eff = fspd_pkg::N_BITS'(fspd_pkg::MAX_PALETTE);
		else n_eff = fspd_pkg::N_BITS'(palette_count_q);
	end
	assign n_last = fspd_pkg::IDX_BITS'(n_eff - fspd_pkg::N_BITS'(1));

	assign in_ready = (state_q == fspd_pkg::ST_IDLE);
	assign accept = in_valid && in_ready;

	// palette RAM
	assign pal_we = accept && !mode && (fspd_pkg::N_BITS'(entry_index) <
		fspd_pkg::N_BITS'(fspd_pkg::MAX_PALETTE));
	assign pal_raddr = (state_q == fspd_pkg::ST_C2) ? i_q + 1'b1 : i_q;

	fspd_ram #(.WIDTH(fspd_pkg::ENT_BITS), .DEPTH(fspd_pkg::MAX_PALETTE)) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (entry_index[fspd_pkg::IDX_BITS-1:0]),
		.wdata ({red, green, blue}),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	// error row RAM
	assign x_d = (fspd_pkg::W_BITS'(col_q) >= w_eff) ? '0 : col_q;
	assign err_raddr = (state_q == fspd_pkg::ST_PIX) ? x_d : x_q;

	fspd_ram #(.WIDTH(fspd_pkg::ERR_WORD_BITS), .DEPTH(fspd_pkg::MAX_WIDTH)) u_err_ram (
		.clk   (clk),
		.we    (err_we),
		.waddr (err_waddr),
		.wdata (err_wdata),
		.raddr (err_raddr),
		.rdata (err_rdata)
	);

	// distance unit, one component per cycle
	always_comb begin
		case (state_q)
			fspd_pkg::ST_C0: begin
				comp_sel = pal_rdata[3*fspd_pkg::COMP_BITS-1:2*fspd_pkg::COMP_BITS];
				val_sel = val_q[0];
			end
			fspd_pkg::ST_C1: begin
				comp_sel = pal_rdata[2*fspd_pkg::COMP_BITS-1:fspd_pkg::COMP_BITS];
				val_sel = val_q[1];
			end
			default: begin
				comp_sel = pal_rdata[fspd_pkg::COMP_BITS-1:0];
				val_sel = val_q[2];
			end
		endcase
	end

	fspd_dist_unit u_dist (
		.comp (comp_sel),
		.val  (val_sel),
		.prod (prod)
	);

	assign dist_sum = acc_q + fspd_pkg::dist_t'(prod);

	// incoming value and error shares
	always_comb begin
		fspd_pkg::wide_t d;
		for (int c = 0; c < 3; c++) begin
			below[c] = err_rdata[(3-c)*fspd_pkg::ERROR_BITS-1 -: fspd_pkg::ERROR_BITS];
			val_d[c] = fspd_pkg::sat(fspd_pkg::wide_t'(fspd_pkg::sat(
				fspd_pkg::wide_t'({1'b0, pix_q[c]}) + fspd_pkg::wide_t'(below[c])))
				+ fspd_pkg::wide_t'(rc_q[c]));
			d = fspd_pkg::wide_t'({1'b0,
				best_ent_q[(3-c)*fspd_pkg::COMP_BITS-1 -: fspd_pkg::COMP_BITS]})
				- fspd_pkg::wide_t'(val_q[c]);
			bl_new[c] = fspd_pkg::sat(fspd_pkg::wide_t'(bl_q[c])
				- fspd_pkg::div16(d * fspd_pkg::wide_t'(3)));
			ln_new[c] = fspd_pkg::sat(fspd_pkg::wide_t'(bh_q[c])
				- fspd_pkg::div16(d * fspd_pkg::wide_t'(5)));
			rc_new[c] = fspd_pkg::sat(-fspd_pkg::div16(d * fspd_pkg::wide_t'(7)));
			bh_new[c] = fspd_pkg::sat(-fspd_pkg::div16(d));
		end
	end

	assign last_d = (fspd_pkg::W_BITS'(x_q) + fspd_pkg::W_BITS'(1)) >= w_eff;

	// sequencer
	always_comb begin
		state_d = state_q;
		err_we = 1'b0;
		err_waddr = x_q;
		err_wdata = '0;
		load_out = 1'b0;
		unique case (state_q)
			fspd_pkg::ST_CLR: begin
				err_we = 1'b1;
				err_waddr = clr_q;
				if (clr_q == fspd_pkg::COL_BITS'(fspd_pkg::MAX_WIDTH - 1))
					state_d = pix_pend_q ? fspd_pkg::ST_PIX : fspd_pkg::ST_IDLE;
			end
			fspd_pkg::ST_IDLE: begin
				if (accept && mode)
					state_d = frame_start ? fspd_pkg::ST_CLR : fspd_pkg::ST_PIX;
			end
			fspd_pkg::ST_PIX: state_d = fspd_pkg::ST_VAL;
			fspd_pkg::ST_VAL: state_d = fspd_pkg::ST_C0;
			fspd_pkg::ST_C0: state_d = fspd_pkg::ST_C1;
			fspd_pkg::ST_C1: state_d = fspd_pkg::ST_C2;
			fspd_pkg::ST_C2: state_d = (i_q == n_last) ? fspd_pkg::ST_DIFF : fspd_pkg::ST_C0;
			fspd_pkg::ST_DIFF: begin
				err_we = (x_q != '0);
				err_waddr = x_q - 1'b1;
				err_wdata = {bl_new[0], bl_new[1], bl_new[2]};
				state_d = last_d ? fspd_pkg::ST_WR2 : fspd_pkg::ST_DONE;
			end
			fspd_pkg::ST_WR2: begin
				err_we = 1'b1;
				err_waddr = x_q;
				err_wdata = {ln_q[0], ln_q[1], ln_q[2]};
				state_d = fspd_pkg::ST_DONE;
			end
			fspd_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = fspd_pkg::ST_IDLE;
				end
			end
			default: state_d = fspd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fspd_pkg::ST_CLR;
			row_width_q <= fspd_pkg::ROW_WIDTH_BITS'(fspd_pkg::ROW_WIDTH_RESET);
			palette_count_q <= fspd_pkg::PALETTE_COUNT_BITS'(fspd_pkg::PALETTE_COUNT_RESET);
			col_q <= '0;
			clr_q <= '0;
			pix_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				rc_q[c] <= '0;
				bl_q[c] <= '0;
				bh_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					fspd_pkg::REG_ROW_WIDTH: row_width_q <= cfg_data;
					fspd_pkg::REG_PALETTE_COUNT:
						palette_count_q <= cfg_data[fspd_pkg::PALETTE_COUNT_BITS-1:0];
					default: ;
				endcase
			end
			if (state_q == fspd_pkg::ST_CLR) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == fspd_pkg::COL_BITS'(fspd_pkg::MAX_WIDTH - 1)) pix_pend_q <= 1'b0;
			end
			if (accept && mode && frame_start) begin
				pix_pend_q <= 1'b1;
				clr_q <= '0;
				col_q <= '0;
				for (int c = 0; c < 3; c++) begin
					rc_q[c] <= '0;
					bl_q[c] <= '0;
					bh_q[c] <= '0;
				end
			end
			if (state_q == fspd_pkg::ST_PIX && fspd_pkg::W_BITS'(col_q) >= w_eff) begin
				col_q <= '0;
				for (int c = 0; c < 3; c++) begin
					rc_q[c] <= '0;
					bl_q[c] <= '0;
					bh_q[c] <= '0;
				end
			end
			if (state_q == fspd_pkg::ST_DIFF && !last_d) begin
				col_q <= x_q + 1'b1;
				for (int c = 0; c < 3; c++) begin
					rc_q[c] <= rc_new[c];
					bh_q[c] <= bh_new[c];
					bl_q[c] <= ln_new[c];
				end
			end
			if (state_q == fspd_pkg::ST_WR2) begin
				col_q <= '0;
				for (int c = 0; c < 3; c++) begin
					rc_q[c] <= '0;
					bl_q[c] <= '0;
					bh_q[c] <= '0;
				end
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q[0] <= red;
			pix_q[1] <= green;
			pix_q[2] <= blue;
		end
		if (state_q == fspd_pkg::ST_PIX) begin
			x_q <= x_d;
			i_q <= '0;
		end
		if (state_q == fspd_pkg::ST_VAL) begin
			for (int c = 0; c < 3; c++) val_q[c] <= val_d[c];
		end
		if (state_q == fspd_pkg::ST_C0) acc_q <= fspd_pkg::dist_t'(prod);
		if (state_q == fspd_pkg::ST_C1) acc_q <= dist_sum;
		if (state_q == fspd_pkg::ST_C2) begin
			if (i_q == '0 || dist_sum < best_dist_q) begin
				best_dist_q <= dist_sum;
				best_q <= i_q;
				best_ent_q <= pal_rdata;
			end
			i_q <= i_q + 1'b1;
		end
		if (state_q == fspd_pkg::ST_DIFF) begin
			last_q <= last_d;
			for (int c = 0; c < 3; c++) ln_q[c] <= ln_new[c];
		end
		if (load_out) begin
			palette_index_q <= fspd_pkg::PALETTE_INDEX_BITS'(best_q);
			row_end_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign palette_index = palette_index_q;
	assign row_end = row_end_q;

endmodule

FILE: sv/fspd_ram.sv
// Generic single write port RAM with registered read.
module fspd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/fspd_dist_unit.sv
// Shared distance term unit: t * floor(t / 256) for one color component.
module fspd_dist_unit (
	input  logic [fspd_pkg::COMP_BITS-1:0] comp,
	input  fspd_pkg::err_t                 val,
	output fspd_pkg::prod_t                prod
);

	fspd_pkg::t_t t;
	logic signed [fspd_pkg::T_BITS-9:0] fs;

	assign t = fspd_pkg::t_t'({1'b0, comp}) - fspd_pkg::t_t'(val);
	assign fs = t[fspd_pkg::T_BITS-1:8];
	assign prod = t * fs;

endmodule
